FILE: sv/lge_pkg.sv
// ----------------------------------------------------------------------------
// lge_pkg: shared types and constants of the life generation engine
// Beat layouts of the item, result and configuration channels, operation
// codes, register indexes and the B3/S23 rule counts.
// ----------------------------------------------------------------------------
package lge_pkg;

    // Default grid bounds for the top-level parameters.
    localparam int DEF_MAX_ROWS = 64;
    localparam int DEF_MAX_COLS = 64;

    // Field widths fixed by the channel formats.
    localparam int FUNC_W  = 2;
    localparam int ROW_W   = 6;
    localparam int COL_W   = 6;
    localparam int GRID_W  = 7;
    localparam int GEN_W   = 16;
    localparam int CFG_IDX_W = 1;

    // Operation codes.
    localparam logic [FUNC_W-1:0] FUNC_WRITE   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_ADVANCE = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_READ    = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_COLS = 1'd1;

    // Reset size of the grid in use.
    localparam logic [GRID_W-1:0] GRID_RESET = 7'd64;

    // Window counts (center included) of the rule.
    localparam logic [3:0] CNT_BIRTH = 4'd3;
    localparam logic [3:0] CNT_KEEP  = 4'd4;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [ROW_W-1:0]  row_index;
        logic [COL_W-1:0]  col_index;
        logic              cell_value;
    } t_in_item;

    typedef struct packed {
        logic             read_value;
        logic             any_alive;
        logic [GEN_W-1:0] generation_count;
    } t_out_item;

    typedef struct packed {
        logic [CFG_IDX_W-1:0] index;
        logic [GRID_W-1:0]    value;
    } t_cfg_beat;

endpackage

FILE: sv/lge_if.sv
// ----------------------------------------------------------------------------
// lge_if: valid/ready channels of the life generation engine
// One interface for each channel: command items, results and
// configuration writes.
// ----------------------------------------------------------------------------
interface lge_in_if;
    logic              valid;
    logic              ready;
    lge_pkg::t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface lge_out_if;
    logic               valid;
    logic               ready;
    lge_pkg::t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface lge_cfg_if;
    logic               valid;
    logic               ready;
    lge_pkg::t_cfg_beat data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: sv/life_generation_engine_core.sv
// ----------------------------------------------------------------------------
// life_generation_engine_core: Game of Life (B3/S23) grid engine
// Write and read items: the addressed row is read and then modified or picked, then
// the row scan of the grid memory sets the alive flag; unknown items run only the scan.
// Advance: one memory row read and written per cycle.
// One item at a time; a result may wait in the output register meanwhile.
// After reset a clearing pass zeroes every word of both banks of the grid memory;
// no item is accepted during it.
// ----------------------------------------------------------------------------
module life_generation_engine_core #(
    parameter int MAX_ROWS = lge_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLS = lge_pkg::DEF_MAX_COLS
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    lge_in_if.sink       i_in,
    lge_out_if.source    o_out,
    lge_cfg_if.sink      i_cfg
);

    localparam int RA        = $clog2(MAX_ROWS);
    localparam int MA        = RA + 1;
    localparam int MEM_DEPTH = 2 ** MA;
    localparam int CA        = $clog2(MAX_COLS);
    localparam int RCW       = $clog2(MAX_ROWS + 1);
    localparam int CCW       = $clog2(MAX_COLS + 1);
    localparam int AW        = $clog2(MAX_ROWS + 2);

    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,
        S_IDLE  = 6'b000010,
        S_ITEM  = 6'b000100,
        S_ADV   = 6'b001000,
        S_SCAN  = 6'b010000,
        S_DONE  = 6'b100000
    } t_state;

    t_state r_state, n_state;

    // Grid memory: bank bit above the row address, one row per word.
    logic [MAX_COLS-1:0] r_mem [MEM_DEPTH];
    logic [MAX_COLS-1:0] r_rd_data;
    logic                mem_re;
    logic [MA-1:0]       mem_raddr;
    logic                mem_we;
    logic [MA-1:0]       mem_waddr;
    logic [MAX_COLS-1:0] mem_wdata;

    logic [MA-1:0]                r_clr_addr, n_clr_addr;
    logic [AW-1:0]                r_cnt, n_cnt;
    logic                         r_bank, n_bank;
    logic [lge_pkg::GEN_W-1:0]    r_gen, n_gen;
    logic                         r_alive, n_alive;
    logic                         r_rd_value, n_rd_value;
    logic [lge_pkg::FUNC_W-1:0]   r_func, n_func;
    logic [lge_pkg::ROW_W-1:0]    r_row, n_row;
    logic [lge_pkg::COL_W-1:0]    r_col, n_col;
    logic                         r_val, n_val;
    logic [MAX_COLS-1:0]          r_prev, n_prev;
    logic [MAX_COLS-1:0]          r_cur, n_cur;
    logic [lge_pkg::GRID_W-1:0]   r_grid_rows, n_grid_rows;
    logic [lge_pkg::GRID_W-1:0]   r_grid_cols, n_grid_cols;
    logic                         r_out_valid, n_out_valid;
    lge_pkg::t_out_item           r_out_data, n_out_data;

    logic [RCW-1:0]      used_rows;
    logic [CCW-1:0]      used_cols;
    logic [MAX_COLS-1:0] col_mask;
    logic                item_inside;
    logic                out_free;
    logic [MAX_COLS-1:0] adv_next_row;
    logic                adv_row_live;
    logic [MAX_COLS-1:0] adv_new_row;
    logic [AW-1:0]       adv_wrow;

    // Grid size in use, limited to 1..MAX.
    always_comb begin
        if (r_grid_rows == '0) begin
            used_rows = RCW'(1);
        end else if (32'(r_grid_rows) > 32'(MAX_ROWS)) begin
            used_rows = RCW'(MAX_ROWS);
        end else begin
            used_rows = RCW'(r_grid_rows);
        end
        if (r_grid_cols == '0) begin
            used_cols = CCW'(1);
        end else if (32'(r_grid_cols) > 32'(MAX_COLS)) begin
            used_cols = CCW'(MAX_COLS);
        end else begin
            used_cols = CCW'(r_grid_cols);
        end
    end

    // Columns in use.
    always_comb begin
        for (int c = 0; c < MAX_COLS; c++) begin
            col_mask[c] = (32'(c) < 32'(used_cols));
        end
    end

    assign item_inside = (32'(r_row) < 32'(used_rows)) && (32'(r_col) < 32'(used_cols));
    assign out_free    = !r_out_valid || o_out.ready;

    // Advance window: the row read in the previous step becomes the next row.
    assign adv_next_row = ((r_cnt != '0) && (r_cnt <= AW'(used_rows))) ?
                          (r_rd_data & col_mask) : '0;
    assign adv_wrow     = AW'(r_cnt - AW'(2));
    assign adv_row_live = (r_cnt >= AW'(2)) && (adv_wrow < AW'(used_rows));

    lge_row_rule #(
        .MAX_COLS (MAX_COLS)
    ) u_row_rule (
        .i_prev     (r_prev),
        .i_cur      (r_cur),
        .i_next     (adv_next_row),
        .i_col_mask (col_mask),
        .i_row_live (adv_row_live),
        .o_new_row  (adv_new_row)
    );

    assign i_in.ready  = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out_data;

    // Sequencer and next-state logic.
    always_comb begin
        n_state     = r_state;
        n_clr_addr  = r_clr_addr;
        n_cnt       = r_cnt;
        n_bank      = r_bank;
        n_gen       = r_gen;
        n_alive     = r_alive;
        n_rd_value  = r_rd_value;
        n_func      = r_func;
        n_row       = r_row;
        n_col       = r_col;
        n_val       = r_val;
        n_prev      = r_prev;
        n_cur       = r_cur;
        n_grid_rows = r_grid_rows;
        n_grid_cols = r_grid_cols;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        mem_re      = 1'b0;
        mem_raddr   = '0;
        mem_we      = 1'b0;
        mem_waddr   = '0;
        mem_wdata   = '0;

        // Configuration writes are taken in any state.
        if (i_cfg.valid) begin
            unique case (i_cfg.data.index)
                lge_pkg::REG_GRID_ROWS: n_grid_rows = i_cfg.data.value;
                lge_pkg::REG_GRID_COLS: n_grid_cols = i_cfg.data.value;
            endcase
        end

        // The output register empties when its beat is taken.
        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_CLEAR: begin
                mem_we     = 1'b1;
                mem_waddr  = r_clr_addr;
                n_clr_addr = r_clr_addr + MA'(1);
                if (r_clr_addr == '1) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in.valid) begin
                    n_func     = i_in.data.func;
                    n_row      = i_in.data.row_index;
                    n_col      = i_in.data.col_index;
                    n_val      = i_in.data.cell_value;
                    n_rd_value = 1'b0;
                    n_cnt      = '0;
                    n_alive    = 1'b0;
                    n_prev     = '0;
                    n_cur      = '0;
                    mem_re     = 1'b1;
                    mem_raddr  = {r_bank, RA'(i_in.data.row_index)};
                    case (i_in.data.func) inside
                        lge_pkg::FUNC_WRITE, lge_pkg::FUNC_READ: n_state = S_ITEM;
                        lge_pkg::FUNC_ADVANCE:                   n_state = S_ADV;
                        default:                                 n_state = S_SCAN;
                    endcase
                end
            end
            S_ITEM: begin
                // The addressed row is back: modify and write it, or pick the cell.
                if (item_inside) begin
                    if (r_func == lge_pkg::FUNC_WRITE) begin
                        mem_we               = 1'b1;
                        mem_waddr            = {r_bank, RA'(r_row)};
                        mem_wdata            = r_rd_data;
                        mem_wdata[CA'(r_col)] = r_val;
                    end else begin
                        n_rd_value = r_rd_data[CA'(r_col)];
                    end
                end
                n_state = S_SCAN;
            end
            S_SCAN: begin
                // Read each row in use; the data of the previous row is ORed in.
                if (r_cnt < AW'(used_rows)) begin
                    mem_re    = 1'b1;
                    mem_raddr = {r_bank, RA'(r_cnt)};
                end
                if (r_cnt != '0) begin
                    n_alive = r_alive | (|(r_rd_data & col_mask));
                end
                if (r_cnt == AW'(used_rows)) begin
                    n_state = S_DONE;
                end else begin
                    n_cnt = r_cnt + AW'(1);
                end
            end
            S_ADV: begin
                // Read the current bank, write the new generation to the other.
                if (r_cnt < AW'(used_rows)) begin
                    mem_re    = 1'b1;
                    mem_raddr = {r_bank, RA'(r_cnt)};
                end
                if (r_cnt >= AW'(2)) begin
                    mem_we    = 1'b1;
                    mem_waddr = {~r_bank, RA'(adv_wrow)};
                    mem_wdata = adv_new_row;
                    n_alive   = r_alive | (|adv_new_row);
                end
                n_prev = r_cur;
                n_cur  = adv_next_row;
                if (r_cnt == AW'(MAX_ROWS + 1)) begin
                    n_bank  = ~r_bank;
                    n_gen   = r_gen + lge_pkg::GEN_W'(1);
                    n_state = S_DONE;
                end else begin
                    n_cnt = r_cnt + AW'(1);
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_out_valid                 = 1'b1;
                    n_out_data.read_value       = r_rd_value;
                    n_out_data.any_alive        = r_alive;
                    n_out_data.generation_count = r_gen;
                    n_state                     = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    // Grid memory ports.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rd_data <= r_mem[mem_raddr];
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_bank      <= 1'b0;
            r_gen       <= '0;
            r_alive     <= 1'b0;
            r_grid_rows <= lge_pkg::GRID_RESET;
            r_grid_cols <= lge_pkg::GRID_RESET;
            r_out_valid <= 1'b0;
            r_cnt       <= '0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_bank      <= n_bank;
            r_gen       <= n_gen;
            r_alive     <= n_alive;
            r_grid_rows <= n_grid_rows;
            r_grid_cols <= n_grid_cols;
            r_out_valid <= n_out_valid;
            r_cnt       <= n_cnt;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_rd_value <= n_rd_value;
        r_func     <= n_func;
        r_row      <= n_row;
        r_col      <= n_col;
        r_val      <= n_val;
        r_prev     <= n_prev;
        r_cur      <= n_cur;
        r_out_data <= n_out_data;
    end

    // An advance never writes into the bank it reads from.
    a_adv_other_bank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ADV) && mem_we |-> mem_waddr[RA] != r_bank)
        else $error("advance wrote into the current bank");

    // A single-cell item modifies the grid only for a write.
    a_item_write_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ITEM) && mem_we |-> r_func == lge_pkg::FUNC_WRITE)
        else $error("grid modified by a non-write item");

    // Finishing an advance steps the generation count by one.
    a_gen_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ADV) && (r_cnt == AW'(MAX_ROWS + 1))
        |=> r_gen == $past(r_gen) + lge_pkg::GEN_W'(1))
        else $error("generation count did not advance");

endmodule

FILE: sv/lge_row_rule.sv
// ----------------------------------------------------------------------------
// lge_row_rule: one row of the next generation
// One lane per column counts the live cells of the 3x3 window over the
// previous, current and next rows and applies the B3/S23 rule.
// ----------------------------------------------------------------------------
module lge_row_rule #(
    parameter int MAX_COLS = lge_pkg::DEF_MAX_COLS
) (
    input  logic [MAX_COLS-1:0] i_prev,
    input  logic [MAX_COLS-1:0] i_cur,
    input  logic [MAX_COLS-1:0] i_next,
    input  logic [MAX_COLS-1:0] i_col_mask,
    input  logic                i_row_live,
    output logic [MAX_COLS-1:0] o_new_row
);

    logic [MAX_COLS+1:0] pad_prev;
    logic [MAX_COLS+1:0] pad_cur;
    logic [MAX_COLS+1:0] pad_next;

    // Dead cells on both sides of the row stand for the grid border.
    assign pad_prev = {1'b0, i_prev, 1'b0};
    assign pad_cur  = {1'b0, i_cur, 1'b0};
    assign pad_next = {1'b0, i_next, 1'b0};

    // Window count and rule for every column lane.
    always_comb begin
        logic [3:0] cnt;
        logic       keep;
        cnt  = '0;
        keep = 1'b0;
        for (int c = 0; c < MAX_COLS; c++) begin
            cnt = 4'(pad_prev[c]) + 4'(pad_prev[c+1]) + 4'(pad_prev[c+2])
                + 4'(pad_cur[c])  + 4'(pad_cur[c+1])  + 4'(pad_cur[c+2])
                + 4'(pad_next[c]) + 4'(pad_next[c+1]) + 4'(pad_next[c+2]);
            if (pad_cur[c+1]) begin
                keep = (cnt == lge_pkg::CNT_BIRTH) || (cnt == lge_pkg::CNT_KEEP);
            end else begin
                keep = (cnt == lge_pkg::CNT_BIRTH);
            end
            o_new_row[c] = keep && i_col_mask[c] && i_row_live;
        end
    end

endmodule

FILE: dv/tb_life_generation_engine_core.sv
// ----------------------------------------------------------------------------
// tb_life_generation_engine_core: self-checking bench for the life engine
// Drives write, advance, read and unknown commands over several grid sizes,
// including out-of-range sizes that clamp. A software copy of the grid
// predicts each result beat, and every beat is compared field by field.
// ----------------------------------------------------------------------------
module tb_life_generation_engine_core;

    localparam int ROWS_MAX     = lge_pkg::DEF_MAX_ROWS;
    localparam int COLS_MAX     = lge_pkg::DEF_MAX_COLS;
    localparam int FUNC_BITS    = lge_pkg::FUNC_W;
    localparam int ROW_BITS     = lge_pkg::ROW_W;
    localparam int COL_BITS     = lge_pkg::COL_W;
    localparam int GRID_BITS    = lge_pkg::GRID_W;
    localparam int HALF_PERIOD  = 10;
    localparam int RESET_CYCLES = 5;
    localparam int MAX_GAP      = 16;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 100;
    localparam int STALL_LIMIT  = 4000;
    localparam logic [FUNC_BITS-1:0] FUNC_UNKNOWN = 2'd3;

    // Software copy of the grid that predicts every result beat.
    class life_grid_model;
        bit                         cells[ROWS_MAX][COLS_MAX];
        logic [GRID_BITS-1:0]       rows_cfg = lge_pkg::GRID_RESET;
        logic [GRID_BITS-1:0]       cols_cfg = lge_pkg::GRID_RESET;
        logic [lge_pkg::GEN_W-1:0]  generation = '0;
        lge_pkg::t_out_item         pending_results[$];
        int                         mismatch_count = 0;

        function int rows_in_use();
            if (rows_cfg < 1) return 1;
            if (rows_cfg > ROWS_MAX) return ROWS_MAX;
            return rows_cfg;
        endfunction

        function int cols_in_use();
            if (cols_cfg < 1) return 1;
            if (cols_cfg > COLS_MAX) return COLS_MAX;
            return cols_cfg;
        endfunction

        function void set_register(logic [lge_pkg::CFG_IDX_W-1:0] idx,
                                   logic [GRID_BITS-1:0] value);
            if (idx == lge_pkg::REG_GRID_ROWS) begin
                rows_cfg = value;
            end else begin
                cols_cfg = value;
            end
        endfunction

        // Only cells inside the grid in use count toward the alive flag.
        function bit any_live();
            for (int r = 0; r < rows_in_use(); r++) begin
                for (int c = 0; c < cols_in_use(); c++) begin
                    if (cells[r][c]) return 1'b1;
                end
            end
            return 1'b0;
        endfunction

        // One generation of B3/S23 with the center counted in the window.
        function void step_generation();
            bit nxt[ROWS_MAX][COLS_MAX];
            int nr;
            int nc;
            int live;
            int rr;
            int cc;
            nr = rows_in_use();
            nc = cols_in_use();
            nxt = '{default: '0};
            for (int r = 0; r < nr; r++) begin
                for (int c = 0; c < nc; c++) begin
                    live = 0;
                    for (int dr = -1; dr <= 1; dr++) begin
                        for (int dc = -1; dc <= 1; dc++) begin
                            rr = r + dr;
                            cc = c + dc;
                            if (rr >= 0 && rr < nr && cc >= 0 && cc < nc) begin
                                live += cells[rr][cc];
                            end
                        end
                    end
                    if (cells[r][c]) begin
                        nxt[r][c] = (live == lge_pkg::CNT_BIRTH) ||
                                    (live == lge_pkg::CNT_KEEP);
                    end else begin
                        nxt[r][c] = (live == lge_pkg::CNT_BIRTH);
                    end
                end
            end
            cells = nxt;
            generation = generation + 1'b1;
        endfunction

        // Applies one accepted command and queues the result it must produce.
        function void apply_command(lge_pkg::t_in_item cmd);
            lge_pkg::t_out_item exp_beat;
            bit                 in_grid;
            in_grid = (cmd.row_index < rows_in_use()) && (cmd.col_index < cols_in_use());
            exp_beat.read_value = 1'b0;
            case (cmd.func)
                lge_pkg::FUNC_WRITE: begin
                    if (in_grid) cells[cmd.row_index][cmd.col_index] = cmd.cell_value;
                end
                lge_pkg::FUNC_ADVANCE: begin
                    step_generation();
                end
                lge_pkg::FUNC_READ: begin
                    if (in_grid) exp_beat.read_value = cells[cmd.row_index][cmd.col_index];
                end
                default: begin
                    // An unknown operation leaves the grid untouched.
                end
            endcase
            exp_beat.any_alive = any_live();
            exp_beat.generation_count = generation;
            pending_results.push_back(exp_beat);
        endfunction

        task flag_mismatch(string msg);
            mismatch_count++;
            $display("[%0t] result error: %s", $realtime, msg);
        endtask

        // Compares one result beat with the oldest prediction.
        task match_result(lge_pkg::t_out_item got);
            lge_pkg::t_out_item exp_beat;
            if (pending_results.size() == 0) begin
                flag_mismatch($sformatf("unexpected beat %p", got));
            end else begin
                exp_beat = pending_results.pop_front();
                if (got.read_value !== exp_beat.read_value)
                    flag_mismatch($sformatf("read_value got %b expected %b",
                                            got.read_value, exp_beat.read_value));
                if (got.any_alive !== exp_beat.any_alive)
                    flag_mismatch($sformatf("any_alive got %b expected %b",
                                            got.any_alive, exp_beat.any_alive));
                if (got.generation_count !== exp_beat.generation_count)
                    flag_mismatch($sformatf("generation_count got %0d expected %0d",
                                            got.generation_count,
                                            exp_beat.generation_count));
            end
        endtask
    endclass

    logic i_clk;
    logic i_rst_n;

    lge_in_if  cmd_ch ();
    lge_out_if res_ch ();
    lge_cfg_if cfg_ch ();

    life_grid_model grid_model = new();
    bit             hold_request = 1'b0;
    int             idle_cycles = 0;

    life_generation_engine_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (cmd_ch),
        .o_out   (res_ch),
        .i_cfg   (cfg_ch)
    );

    // Free-running clock.
    always begin
        i_clk = 1'b0;
        #HALF_PERIOD;
        i_clk = 1'b1;
        #HALF_PERIOD;
    end

    // Watchdog: ends the run when no channel moves a beat for too long.
    always @(posedge i_clk) begin
        if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function lge_pkg::t_in_item make_cmd(logic [FUNC_BITS-1:0] func, int row, int col,
                                         bit value);
        lge_pkg::t_in_item cmd;
        cmd.func       = func;
        cmd.row_index  = ROW_BITS'(row);
        cmd.col_index  = COL_BITS'(col);
        cmd.cell_value = value;
        return cmd;
    endfunction

    // Mostly well-formed commands inside the grid, the rest raw noise.
    function lge_pkg::t_in_item random_cmd();
        int  pick;
        int  row;
        int  col;
        pick = $urandom_range(0, 99);
        row  = $urandom_range(0, grid_model.rows_in_use() - 1);
        col  = $urandom_range(0, grid_model.cols_in_use() - 1);
        if (pick < 40)
            return make_cmd(lge_pkg::FUNC_WRITE, row, col, $urandom_range(0, 9) < 6);
        if (pick < 55)
            return make_cmd(lge_pkg::FUNC_ADVANCE, row, col, 1'($urandom_range(0, 1)));
        if (pick < 78)
            return make_cmd(lge_pkg::FUNC_READ, row, col, 1'($urandom_range(0, 1)));
        return make_cmd(FUNC_BITS'($urandom_range(0, 3)), $urandom_range(0, 63),
                        $urandom_range(0, 63), 1'($urandom_range(0, 1)));
    endfunction

    // Offers one command beat and records it once accepted.
    task send_command(input lge_pkg::t_in_item cmd, input bit no_gap);
        int gap;
        gap = no_gap ? 0 : $urandom_range(0, MAX_GAP);
        if (gap != 0) begin
            cmd_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        cmd_ch.valid <= 1'b1;
        cmd_ch.data  <= cmd;
        do @(posedge i_clk); while (cmd_ch.ready !== 1'b1);
        grid_model.apply_command(cmd);
    endtask

    // Stops offering commands and waits for every predicted beat.
    task drain_results();
        cmd_ch.valid <= 1'b0;
        while (grid_model.pending_results.size() != 0) @(posedge i_clk);
    endtask

    // Writes both size registers back to back while the engine is idle.
    task program_grid(input logic [GRID_BITS-1:0] rows, input logic [GRID_BITS-1:0] cols);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= '{index: lge_pkg::REG_GRID_ROWS, value: rows};
        do @(posedge i_clk); while (cfg_ch.ready !== 1'b1);
        grid_model.set_register(lge_pkg::REG_GRID_ROWS, rows);
        cfg_ch.data  <= '{index: lge_pkg::REG_GRID_COLS, value: cols};
        do @(posedge i_clk); while (cfg_ch.ready !== 1'b1);
        grid_model.set_register(lge_pkg::REG_GRID_COLS, cols);
        cfg_ch.valid <= 1'b0;
    endtask

    task run_phase(input logic [GRID_BITS-1:0] rows, input logic [GRID_BITS-1:0] cols,
                   input int count, input bit no_gap, input bit hold);
        program_grid(rows, cols);
        hold_request = hold;
        repeat (count) send_command(random_cmd(), no_gap);
        drain_results();
    endtask

    // Result sink: random stalls, steady stretches and one long hold-off.
    initial begin
        int  stall;
        int  beats_left;
        bit  steady;
        bit  hold_taken;
        beats_left = 0;
        steady     = 1'b0;
        hold_taken = 1'b0;
        res_ch.ready <= 1'b0;
        // The result channel is not sampled until reset has been released.
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            if (beats_left == 0) begin
                steady     = ($urandom_range(0, 2) == 0);
                beats_left = $urandom_range(5, 20);
            end
            beats_left--;
            if (hold_request && !hold_taken) begin
                hold_taken = 1'b1;
                stall = HOLD_CYCLES;
            end else begin
                stall = steady ? 0 : $urandom_range(0, MAX_GAP);
            end
            if (stall != 0) begin
                res_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            res_ch.ready <= 1'b1;
            do @(posedge i_clk); while (res_ch.valid !== 1'b1);
            grid_model.match_result(res_ch.data);
        end
    end

    // Stimulus: directed patterns at the reset size, then random phases.
    initial begin
        cmd_ch.valid <= 1'b0;
        cmd_ch.data  <= '0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.data  <= '0;
        i_rst_n      <= 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Empty grid, then lone corner cells that die out.
        send_command(make_cmd(lge_pkg::FUNC_READ, 0, 0, 1'b1), 1'b0);
        send_command(make_cmd(lge_pkg::FUNC_ADVANCE, 63, 63, 1'b1), 1'b0);
        send_command(make_cmd(lge_pkg::FUNC_WRITE, 0, 0, 1'b1), 1'b0);
        send_command(make_cmd(lge_pkg::FUNC_WRITE, 63, 63, 1'b1), 1'b1);
        send_command(make_cmd(lge_pkg::FUNC_READ, 63, 63, 1'b0), 1'b0);
        send_command(make_cmd(lge_pkg::FUNC_READ, 0, 63, 1'b0), 1'b0);
        send_command(make_cmd(lge_pkg::FUNC_WRITE, 63, 63, 1'b0), 1'b0);
        send_command(make_cmd(lge_pkg::FUNC_ADVANCE, 0, 0, 1'b0), 1'b0);

        // A blinker at row 10 and a still block in the top right corner.
        send_command(make_cmd(lge_pkg::FUNC_WRITE, 10, 9, 1'b1), 1'b1);
        send_command(make_cmd(lge_pkg::FUNC_WRITE, 10, 10, 1'b1), 1'b1);
        send_command(make_cmd(lge_pkg::FUNC_WRITE, 10, 11, 1'b1), 1'b1);
        send_command(make_cmd(lge_pkg::FUNC_WRITE, 0, 62, 1'b1), 1'b0);
        send_command(make_cmd(lge_pkg::FUNC_WRITE, 0, 63, 1'b1), 1'b0);
        send_command(make_cmd(lge_pkg::FUNC_WRITE, 1, 62, 1'b1), 1'b0);
        send_command(make_cmd(lge_pkg::FUNC_WRITE, 1, 63, 1'b1), 1'b0);
        send_command(make_cmd(lge_pkg::FUNC_ADVANCE, 0, 0, 1'b0), 1'b0);
        send_command(make_cmd(lge_pkg::FUNC_READ, 9, 10, 1'b0), 1'b0);
        send_command(make_cmd(lge_pkg::FUNC_READ, 10, 9, 1'b0), 1'b0);
        send_command(make_cmd(lge_pkg::FUNC_READ, 1, 63, 1'b0), 1'b0);
        send_command(make_cmd(FUNC_UNKNOWN, 63, 63, 1'b1), 1'b0);
        send_command(make_cmd(lge_pkg::FUNC_ADVANCE, 0, 0, 1'b0), 1'b0);
        send_command(make_cmd(lge_pkg::FUNC_READ, 10, 11, 1'b1), 1'b0);
        send_command(make_cmd(FUNC_UNKNOWN, 0, 0, 1'b0), 1'b0);
        drain_results();

        // Clamped sizes, extremes, the pressure phase and random sizes.
        run_phase(7'd0, 7'd127, 14, 1'b1, 1'b0);
        run_phase(7'd1, 7'd1, 10, 1'b0, 1'b0);
        run_phase(7'd64, 7'd64, 16, 1'b1, 1'b1);
        run_phase(7'd3, 7'd3, 16, 1'b0, 1'b0);
        run_phase(7'd127, 7'd0, 14, 1'b0, 1'b0);
        run_phase(7'd5, 7'd8, 16, 1'b1, 1'b0);
        run_phase(GRID_BITS'($urandom_range(0, 127)), GRID_BITS'($urandom_range(0, 127)),
                  16, 1'b0, 1'b0);
        run_phase(GRID_BITS'($urandom_range(1, 12)), GRID_BITS'($urandom_range(1, 12)),
                  16, 1'b0, 1'b0);

        // Let any stray beat show up before the verdict.
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (grid_model.mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
